FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/qpd_pkg.sv
// ----------------------------------------------------------------------------
// qpd_pkg
// Types, character codes and helpers for the quoted-printable decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qpd_pkg;

  // character codes
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_US = 8'h5F;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // decoded words per input byte, at most
  localparam int RUN_MAX = 3;
  localparam int RUN_W   = 2;

  // run queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // escape phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EQ   = 2'd1,
    PH_HELD = 2'd2
  } phase_t;

  // one run of decoded words caused by one input byte
  typedef struct packed {
    logic [RUN_W-1:0]           cnt;
    logic [RUN_MAX-1:0][7:0]    bytes;
    logic                       byte_valid;
    logic                       msg_end;
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return r;
  endfunction

  // nibble value of a hex digit; letters have bit 6 set
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] r;
    r = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/quoted_printable_decoder.sv
// ----------------------------------------------------------------------------
// quoted_printable_decoder: throughput one input byte per cycle while in_full
// is low; the serialiser gives one output word per cycle while out_pop takes them;
// an escape error costing up to 3 words is absorbed by a 4-run queue.
// Synchronous active-low reset clears escape state, queue and output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_printable_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // configuration
  input  wire logic          cfg_we,
  input  wire logic          cfg_underscore_as_space,
  // input words
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end_of_input,
  // result words
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_run_last,
  output logic               out_message_end
);

  qpd_pkg::run_t run_w, head_w;
  logic          acc, push_w, q_full, q_empty, q_pop;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  // escape tracker
  qpd_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_underscore_as_space (cfg_underscore_as_space),
    .acc_i                   (acc),
    .in_byte                 (in_byte),
    .in_end_of_input         (in_end_of_input),
    .run_o                   (run_w),
    .push_o                  (push_w)
  );

  // run queue
  qpd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push_w),
    .wdata_i (run_w),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head_w),
    .empty_o (q_empty)
  );

  // serialiser and output register
  qpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_i          (head_w),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

endmodule

`default_nettype wire

FILE: rtl/core/qpd_front.sv
// ----------------------------------------------------------------------------
// qpd_front
// Escape tracker: classifies each input byte and builds its run of words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module qpd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_underscore_as_space,
  input  wire logic          acc_i,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end_of_input,
  output qpd_pkg::run_t      run_o,
  output logic               push_o
);

  qpd_pkg::phase_t phase_r, phase_nxt, phase_mid;
  logic [7:0]      held_r, held_nxt, held_mid;
  logic            us_r;
  logic            do_plain;
  qpd_pkg::run_t   run;
  logic [qpd_pkg::RUN_W-1:0] cnt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_r <= 1'b0;
    end else if (cfg_we) begin
      us_r <= cfg_underscore_as_space;
    end
  end

  // next escape state
  always_comb begin
    do_plain  = 1'b0;
    phase_mid = phase_r;
    held_mid  = held_r;
    case (phase_r)
      qpd_pkg::PH_EQ: begin
        if (in_byte == qpd_pkg::CH_LF) begin
          phase_mid = qpd_pkg::PH_IDLE;
        end else if (in_byte == qpd_pkg::CH_CR || qpd_pkg::is_hex(in_byte)) begin
          held_mid  = in_byte;
          phase_mid = qpd_pkg::PH_HELD;
        end else begin
          phase_mid = qpd_pkg::PH_IDLE;
          do_plain  = 1'b1;
        end
      end
      qpd_pkg::PH_HELD: begin
        phase_mid = qpd_pkg::PH_IDLE;
        if (held_r == qpd_pkg::CH_CR) begin
          do_plain = (in_byte != qpd_pkg::CH_LF);
        end else begin
          do_plain = !(qpd_pkg::is_hex(held_r) && qpd_pkg::is_hex(in_byte));
        end
      end
      default: begin
        phase_mid = qpd_pkg::PH_IDLE;
        do_plain  = 1'b1;
      end
    endcase
    // a plain '=' opens a new escape
    if (do_plain && in_byte == qpd_pkg::CH_EQ) begin
      phase_mid = qpd_pkg::PH_EQ;
    end
    phase_nxt = in_end_of_input ? qpd_pkg::PH_IDLE : phase_mid;
    held_nxt  = in_end_of_input ? 8'h00 : held_mid;
  end

  // run of words for this byte
  always_comb begin
    run            = '0;
    run.byte_valid = 1'b1;
    run.msg_end    = in_end_of_input;
    cnt            = '0;
    // words closing the previous escape
    case (phase_r)
      qpd_pkg::PH_EQ: begin
        if (do_plain) begin
          run.bytes[cnt] = qpd_pkg::CH_EQ;
          cnt            = cnt + 1'b1;
        end
      end
      qpd_pkg::PH_HELD: begin
        if (held_r != qpd_pkg::CH_CR && !do_plain) begin
          run.bytes[cnt] = {qpd_pkg::hex_nib(held_r), qpd_pkg::hex_nib(in_byte)};
          cnt            = cnt + 1'b1;
        end else if (do_plain) begin
          run.bytes[cnt] = qpd_pkg::CH_EQ;
          cnt            = cnt + 1'b1;
          run.bytes[cnt] = held_r;
          cnt            = cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
    // the byte itself outside an escape
    if (do_plain) begin
      if (in_byte == qpd_pkg::CH_US && us_r) begin
        run.bytes[cnt] = qpd_pkg::CH_SP;
        cnt            = cnt + 1'b1;
      end else if (in_byte != qpd_pkg::CH_EQ) begin
        run.bytes[cnt] = in_byte;
        cnt            = cnt + 1'b1;
      end
    end
    // flush a pending escape at end of text
    if (in_end_of_input) begin
      if (phase_mid == qpd_pkg::PH_EQ) begin
        run.bytes[cnt] = qpd_pkg::CH_EQ;
        cnt            = cnt + 1'b1;
      end else if (phase_mid == qpd_pkg::PH_HELD) begin
        run.bytes[cnt] = qpd_pkg::CH_EQ;
        cnt            = cnt + 1'b1;
        run.bytes[cnt] = held_mid;
        cnt            = cnt + 1'b1;
      end
      // bare end marker
      if (cnt == '0) begin
        run.byte_valid = 1'b0;
        cnt            = 2'd1;
      end
    end
    run.cnt = cnt;
  end

  assign run_o  = run;
  assign push_o = acc_i && (cnt != '0);

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qpd_pkg::PH_IDLE;
      held_r  <= 8'h00;
    end else if (acc_i) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  `ASSERT_NEXT(a_end_clears, acc_i && in_end_of_input, phase_r == qpd_pkg::PH_IDLE && held_r == 8'h00, "escape state not cleared after end of text")
  `ASSERT_IMPL(a_held_has_digit, phase_r == qpd_pkg::PH_HELD, held_r == qpd_pkg::CH_CR || qpd_pkg::is_hex(held_r), "held byte is neither CR nor hex")

endmodule

`default_nettype wire

FILE: rtl/core/qpd_fifo.sv
// ----------------------------------------------------------------------------
// qpd_fifo
// Short queue of decoded runs between the escape tracker and the serialiser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module qpd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_i,
  input  qpd_pkg::run_t      wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output qpd_pkg::run_t      head_o,
  output logic               empty_o
);

  qpd_pkg::run_t                  mem_r [qpd_pkg::QDEPTH];
  logic [qpd_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [qpd_pkg::QCNT_W-1:0]     count_r;

  assign full_o  = (count_r == qpd_pkg::QCNT_W'(qpd_pkg::QDEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == qpd_pkg::QPTR_W'(qpd_pkg::QDEPTH - 1)) ? '0
                                                                      : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == qpd_pkg::QPTR_W'(qpd_pkg::QDEPTH - 1)) ? '0
                                                                      : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_no_overflow, full_o, !push_i, "push into full run queue")
  `ASSERT_IMPL(a_no_underflow, empty_o, !pop_i, "pop from empty run queue")

endmodule

`default_nettype wire

FILE: rtl/core/qpd_back.sv
// ----------------------------------------------------------------------------
// qpd_back
// Serialiser: walks the head run one word per cycle into a free output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module qpd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  qpd_pkg::run_t      head_i,
  input  wire logic          q_empty_i,
  output logic               q_pop_o,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_run_last,
  output logic               out_message_end
);

  logic [qpd_pkg::RUN_W-1:0] idx_r, idx_nxt;
  logic                      ov_r, ov_nxt;
  logic [7:0]                byte_r;
  logic                      bvalid_r, last_r, mend_r;
  logic                      load, is_last;

  // load a word when the output slot is free or being taken
  assign load    = !q_empty_i && (!ov_r || out_pop);
  assign is_last = (idx_r == head_i.cnt - 1'b1);
  assign q_pop_o = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
      ov_nxt  = 1'b1;
    end else if (out_pop) begin
      ov_nxt  = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head_i.bytes[idx_r];
      bvalid_r <= head_i.byte_valid;
      last_r   <= is_last;
      mend_r   <= is_last && head_i.msg_end;
    end
  end

  assign out_empty       = !ov_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvalid_r;
  assign out_run_last    = last_r;
  assign out_message_end = mend_r;

  `ASSERT_IMPL(a_idx_in_run, !q_empty_i, idx_r < head_i.cnt, "word index beyond run length")
  `ASSERT_IMPL(a_mend_is_last, ov_r && out_message_end, out_run_last, "message end on a word that is not last of its run")

endmodule

`default_nettype wire
